@@ hdl/gsq_pkg.sv @@
// Shared widths and fixed-point constants for the gamma-square pixel blend.
`timescale 1ns / 1ps
`default_nettype none

package gsq_pkg;

    // Field widths.
    localparam int CH_W    = 8;
    localparam int SQ_W    = 2 * CH_W;
    localparam int PROD_W  = SQ_W + CH_W;
    localparam int TERM_W  = 16;
    localparam int SUM_W   = TERM_W + 1;
    localparam int ROOT_W  = CH_W;

    localparam logic [CH_W-1:0] FULL_SCALE = 8'd255;

    // Squared-domain term: floor(p * 257 / 65025) with p < 2^24 is computed as
    // floor(p * K / 2^40), where K = ceil(257 * 2^40 / 65025). K is just above
    // 2^32, so p * K is split into (p << 32) plus p times the low part of K.
    localparam int SQ_SHIFT = 40;
    localparam longint unsigned SqRecip =
        ((64'd257 << SQ_SHIFT) + 64'd65024) / 64'd65025;
    localparam int RECIP_LO_W = 26;
    localparam logic [RECIP_LO_W-1:0] SQ_RECIP_LO =
        RECIP_LO_W'(SqRecip - (64'd1 << 32));
    localparam int MLO_W  = PROD_W + RECIP_LO_W;
    localparam int FULL_W = PROD_W + 32;

    // Alpha term: floor(x / 255) with x <= 65025 as floor(x * ceil(2^24 / 255) / 2^24).
    localparam int AL_SHIFT   = 24;
    localparam int AL_RECIP_W = 17;
    localparam logic [AL_RECIP_W-1:0] AL_RECIP =
        AL_RECIP_W'(((64'd1 << AL_SHIFT) + 64'd254) / 64'd255);
    localparam int AL_PROD_W  = SQ_W + AL_RECIP_W;
    localparam int AL_STAGES  = 3;

    // Pipeline depth: four stages per squared term, one for the sum, one per
    // root bit.
    localparam int TERM_STAGES = 4;
    localparam int LATENCY     = TERM_STAGES + 1 + ROOT_W;
    localparam int AL_DELAY    = LATENCY - AL_STAGES;

endpackage

`default_nettype wire

@@ hdl/gsq_term.sv @@
// Four-stage pipeline for one weighted squared-domain term.
`timescale 1ns / 1ps
`default_nettype none

module gsq_term (
    input  wire logic                        i_clk,
    input  wire logic [gsq_pkg::CH_W-1:0]    i_chan,
    input  wire logic [gsq_pkg::CH_W-1:0]    i_fac,
    output logic      [gsq_pkg::TERM_W-1:0]  o_term
);

    logic [gsq_pkg::SQ_W-1:0]   r_sq;
    logic [gsq_pkg::CH_W-1:0]   r_fac;
    logic [gsq_pkg::PROD_W-1:0] r_prod;
    logic [gsq_pkg::PROD_W-1:0] r_prod_d;
    logic [gsq_pkg::MLO_W-1:0]  r_mlo;
    logic [gsq_pkg::TERM_W-1:0] r_term;
    logic [gsq_pkg::FULL_W-1:0] n_full;

    // Full product p * K; the quotient sits in the bits above the shift.
    assign n_full = {r_prod_d, 32'd0} + gsq_pkg::FULL_W'(r_mlo);

    always_ff @(posedge i_clk) begin
        r_sq     <= gsq_pkg::SQ_W'(i_chan * i_chan);
        r_fac    <= i_fac;
        r_prod   <= gsq_pkg::PROD_W'(r_sq * r_fac);
        r_mlo    <= gsq_pkg::MLO_W'(r_prod * gsq_pkg::SQ_RECIP_LO);
        r_prod_d <= r_prod;
        r_term   <= n_full[gsq_pkg::SQ_SHIFT +: gsq_pkg::TERM_W];
    end

    assign o_term = r_term;

endmodule

`default_nettype wire

@@ hdl/gsq_isqrt.sv @@
// Sum of the two terms and a one-bit-per-stage integer square root pipeline.
`timescale 1ns / 1ps
`default_nettype none

module gsq_isqrt (
    input  wire logic                        i_clk,
    input  wire logic [gsq_pkg::TERM_W-1:0]  i_term_a,
    input  wire logic [gsq_pkg::TERM_W-1:0]  i_term_b,
    output logic      [gsq_pkg::ROOT_W-1:0]  o_root
);

    logic [gsq_pkg::SUM_W-1:0]  r_sum  [gsq_pkg::ROOT_W];
    logic [gsq_pkg::ROOT_W-1:0] r_root [1:gsq_pkg::ROOT_W];

    always_ff @(posedge i_clk) begin
        r_sum[0] <= gsq_pkg::SUM_W'(i_term_a) + gsq_pkg::SUM_W'(i_term_b);
    end

    // Stage k decides root bit ROOT_W-k, most significant first.
    for (genvar k = 1; k <= gsq_pkg::ROOT_W; k++) begin : g_stage
        localparam logic [gsq_pkg::ROOT_W-1:0] TrialBit =
            gsq_pkg::ROOT_W'(1 << (gsq_pkg::ROOT_W - k));
        logic [gsq_pkg::ROOT_W-1:0] w_prev;
        logic [gsq_pkg::ROOT_W-1:0] w_trial;
        logic [gsq_pkg::SQ_W-1:0]   w_sq;

        if (k == 1) begin : g_first
            assign w_prev = '0;
        end else begin : g_next
            assign w_prev = r_root[k-1];
        end

        assign w_trial = w_prev | TrialBit;
        assign w_sq    = gsq_pkg::SQ_W'(w_trial * w_trial);

        always_ff @(posedge i_clk) begin
            if (gsq_pkg::SUM_W'(w_sq) <= r_sum[k-1]) begin
                r_root[k] <= w_trial;
            end else begin
                r_root[k] <= w_prev;
            end
        end

        if (k < gsq_pkg::ROOT_W) begin : g_carry
            always_ff @(posedge i_clk) begin
                r_sum[k] <= r_sum[k-1];
            end
        end
    end

    assign o_root = r_root[gsq_pkg::ROOT_W];

endmodule

`default_nettype wire

@@ hdl/gamma_square_pixel_blend.sv @@
// Top level of the gamma-square pixel blend: channel and alpha pipelines.
//
//  Channel   Direction  Transfer when         Payload
//  input     in         start && !busy        i_channel_a, i_channel_b, i_alpha_a,
//                                             i_alpha_b, i_weight
//  result    out        o_done (one cycle)    o_mixed_channel, o_mixed_alpha
//
// One pixel enters per clock cycle while busy is low; its result follows the input
// transfer through the squared-term stages, the sum stage and the
// one-bit-per-stage square root (the alpha path is delayed to match).
// The pipeline never stalls, since the receiver cannot hold results off.
// busy is high only during reset and the cycle after it is released.
// Reset clears the valid bits; data registers carry no reset.
`timescale 1ns / 1ps
`default_nettype none

module gamma_square_pixel_blend (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic [gsq_pkg::CH_W-1:0]  i_channel_a,
    input  wire logic [gsq_pkg::CH_W-1:0]  i_channel_b,
    input  wire logic [gsq_pkg::CH_W-1:0]  i_alpha_a,
    input  wire logic [gsq_pkg::CH_W-1:0]  i_alpha_b,
    input  wire logic [gsq_pkg::CH_W-1:0]  i_weight,
    output logic                           o_done,
    output logic      [gsq_pkg::CH_W-1:0]  o_mixed_channel,
    output logic      [gsq_pkg::CH_W-1:0]  o_mixed_alpha
);

    logic                             w_accept;
    logic [gsq_pkg::CH_W-1:0]         w_inv_weight;
    logic [gsq_pkg::TERM_W-1:0]       w_term_a;
    logic [gsq_pkg::TERM_W-1:0]       w_term_b;

    logic                             r_busy;
    logic [gsq_pkg::LATENCY-1:0]      r_vld;
    logic [gsq_pkg::SQ_W-1:0]         r_al_pa;
    logic [gsq_pkg::SQ_W-1:0]         r_al_pb;
    logic [gsq_pkg::AL_PROD_W-1:0]    r_al_ma;
    logic [gsq_pkg::AL_PROD_W-1:0]    r_al_mb;
    logic [gsq_pkg::CH_W-1:0]         r_al_dly [gsq_pkg::AL_DELAY+1];

    assign w_accept     = start && !r_busy;
    assign w_inv_weight = gsq_pkg::FULL_SCALE - i_weight;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_vld  <= '0;
        end else begin
            r_busy <= 1'b0;
            r_vld  <= {r_vld[gsq_pkg::LATENCY-2:0], w_accept};
        end
    end

    gsq_term u_term_a (
        .i_clk  (i_clk),
        .i_chan (i_channel_a),
        .i_fac  (w_inv_weight),
        .o_term (w_term_a)
    );

    gsq_term u_term_b (
        .i_clk  (i_clk),
        .i_chan (i_channel_b),
        .i_fac  (i_weight),
        .o_term (w_term_b)
    );

    gsq_isqrt u_isqrt (
        .i_clk    (i_clk),
        .i_term_a (w_term_a),
        .i_term_b (w_term_b),
        .o_root   (o_mixed_channel)
    );

    // Alpha: weight, divide by 255 through a reciprocal, add, then delay to
    // line up with the channel result.
    always_ff @(posedge i_clk) begin
        r_al_pa     <= gsq_pkg::SQ_W'(i_alpha_a * w_inv_weight);
        r_al_pb     <= gsq_pkg::SQ_W'(i_alpha_b * i_weight);
        r_al_ma     <= gsq_pkg::AL_PROD_W'(r_al_pa * gsq_pkg::AL_RECIP);
        r_al_mb     <= gsq_pkg::AL_PROD_W'(r_al_pb * gsq_pkg::AL_RECIP);
        r_al_dly[0] <= r_al_ma[gsq_pkg::AL_SHIFT +: gsq_pkg::CH_W]
                     + r_al_mb[gsq_pkg::AL_SHIFT +: gsq_pkg::CH_W];
        for (int i = 1; i <= gsq_pkg::AL_DELAY; i++) begin
            r_al_dly[i] <= r_al_dly[i-1];
        end
    end

    assign busy          = r_busy;
    assign o_done        = r_vld[gsq_pkg::LATENCY-1];
    assign o_mixed_alpha = r_al_dly[gsq_pkg::AL_DELAY];

    // A result strobe always traces back to an input transfer a fixed time earlier.
    a_done_from_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(w_accept, gsq_pkg::LATENCY))
        else $error("result strobe without a matching input transfer");

    // Zero weight passes the first source through unchanged.
    a_weight_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(i_weight == '0, gsq_pkg::LATENCY))
        |-> (o_mixed_channel == $past(i_channel_a, gsq_pkg::LATENCY)
             && o_mixed_alpha == $past(i_alpha_a, gsq_pkg::LATENCY)))
        else $error("zero weight did not return the first source");

    // Full weight passes the second source through unchanged.
    a_weight_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(i_weight == gsq_pkg::FULL_SCALE, gsq_pkg::LATENCY))
        |-> (o_mixed_channel == $past(i_channel_b, gsq_pkg::LATENCY)
             && o_mixed_alpha == $past(i_alpha_b, gsq_pkg::LATENCY)))
        else $error("full weight did not return the second source");

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the gamma-square pixel blend: driver, monitor and blend predictor.
`timescale 1ns / 1ps

module tb_top;

    localparam int CW = gsq_pkg::CH_W;

    localparam int unsigned MAX_LEVEL   = 255;
    localparam int unsigned SQ_NUM      = 257;
    localparam int unsigned SQ_DEN      = 65025;
    localparam int unsigned ROOT_TOP    = 256;
    localparam int          N_RANDOM    = 2000;
    localparam int          IDLE_PCT    = 23;
    localparam int          CALM_FIRST  = 900;
    localparam int          CALM_LAST   = 1200;
    localparam int          STALL_LIMIT = 2000;

    typedef struct packed {
        logic [CW-1:0] channel_a;
        logic [CW-1:0] channel_b;
        logic [CW-1:0] alpha_a;
        logic [CW-1:0] alpha_b;
        logic [CW-1:0] weight;
    } t_pixel;

    typedef struct packed {
        logic [CW-1:0] mixed_channel;
        logic [CW-1:0] mixed_alpha;
    } t_blend;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          start = 1'b0;
    logic          busy;
    logic [CW-1:0] i_channel_a = '0;
    logic [CW-1:0] i_channel_b = '0;
    logic [CW-1:0] i_alpha_a = '0;
    logic [CW-1:0] i_alpha_b = '0;
    logic [CW-1:0] i_weight = '0;
    logic          o_done;
    logic [CW-1:0] o_mixed_channel;
    logic [CW-1:0] o_mixed_alpha;

    t_pixel pending_pixels[$];
    t_blend expected_blends[$];
    int     pixels_sent = 0;
    int     blends_checked = 0;
    int     edge_weights = 0;
    int     n_directed = 0;
    int     errors = 0;
    int     stall_cycles = 0;

    gamma_square_pixel_blend dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_channel_a     (i_channel_a),
        .i_channel_b     (i_channel_b),
        .i_alpha_a       (i_alpha_a),
        .i_alpha_b       (i_alpha_b),
        .i_weight        (i_weight),
        .o_done          (o_done),
        .o_mixed_channel (o_mixed_channel),
        .o_mixed_alpha   (o_mixed_alpha)
    );

    always #1 i_clk = ~i_clk;

    // Squares each channel back to linear light, weights the two terms with
    // separate floors, and takes the floor square root of their sum; alpha is weighted with separate floors too.
    function automatic t_blend predict_blend(t_pixel px);
        longint unsigned ca, cb, w, wp, sum, root, trial;
        int unsigned     alpha;
        t_blend          res;
        ca = px.channel_a;
        cb = px.channel_b;
        w  = px.weight;
        wp = MAX_LEVEL - w;
        sum = (ca * ca * wp * SQ_NUM) / SQ_DEN + (cb * cb * w * SQ_NUM) / SQ_DEN;
        root = 0;
        for (longint unsigned b = ROOT_TOP; b != 0; b = b >> 1) begin
            trial = root | b;
            if (trial * trial <= sum) begin
                root = trial;
            end
        end
        alpha = (int'(px.alpha_a) * int'(wp)) / MAX_LEVEL
              + (int'(px.alpha_b) * int'(w)) / MAX_LEVEL;
        res.mixed_channel = root[CW-1:0];
        res.mixed_alpha   = alpha[CW-1:0];
        return res;
    endfunction

    function automatic logic [CW-1:0] pick_level();
        case ($urandom_range(4))
            0: return '0;
            1: return '1;
            2: return 8'd1;
            3: return 8'd254;
            default: return CW'($urandom);
        endcase
    endfunction

    function automatic t_pixel random_pixel();
        t_pixel px;
        if ($urandom_range(99) < 70) begin
            px = {CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom),
                  CW'($urandom)};
        end else begin
            px = {pick_level(), pick_level(), pick_level(), pick_level(), pick_level()};
        end
        return px;
    endfunction

    // Driver: keeps the head pixel on the ports until it is transferred.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                expected_blends.push_back(predict_blend(pending_pixels[0]));
                if (pending_pixels[0].weight == '0 || pending_pixels[0].weight == '1) begin
                    edge_weights++;
                end
                pending_pixels.pop_front();
                pixels_sent++;
            end
            if (!start || !busy) begin
                if (pending_pixels.size() != 0 &&
                    ((pixels_sent >= CALM_FIRST && pixels_sent < CALM_LAST) ||
                     $urandom_range(99) >= IDLE_PCT)) begin
                    start       <= 1'b1;
                    i_channel_a <= pending_pixels[0].channel_a;
                    i_channel_b <= pending_pixels[0].channel_b;
                    i_alpha_a   <= pending_pixels[0].alpha_a;
                    i_alpha_b   <= pending_pixels[0].alpha_b;
                    i_weight    <= pending_pixels[0].weight;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: every strobed result is matched against the oldest prediction.
    always @(posedge i_clk) begin
        t_blend want;
        if (i_rst_n) begin
            if ($isunknown(o_done)) begin
                $error("o_done is unknown after reset");
                errors++;
            end else if (o_done) begin
                if (expected_blends.size() == 0) begin
                    $error("unexpected result: mixed_channel %0d mixed_alpha %0d",
                           o_mixed_channel, o_mixed_alpha);
                    errors++;
                end else begin
                    want = expected_blends.pop_front();
                    blends_checked++;
                    if (o_mixed_channel !== want.mixed_channel) begin
                        $error("mixed_channel: expected %0d, actual %0d",
                               want.mixed_channel, o_mixed_channel);
                        errors++;
                    end
                    if (o_mixed_alpha !== want.mixed_alpha) begin
                        $error("mixed_alpha: expected %0d, actual %0d",
                               want.mixed_alpha, o_mixed_alpha);
                        errors++;
                    end
                end
            end
        end
    end

    // Watchdog on cycles with neither an input transfer nor a result.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done === 1'b1) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("Verification failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        t_pixel px;
        // Weight at both ends, where one source passes through untouched.
        pending_pixels.push_back({8'd0,   8'd0,   8'd0,   8'd0,   8'd0});
        pending_pixels.push_back({8'd255, 8'd255, 8'd255, 8'd255, 8'd255});
        pending_pixels.push_back({8'd255, 8'd0,   8'd255, 8'd0,   8'd0});
        pending_pixels.push_back({8'd255, 8'd0,   8'd255, 8'd0,   8'd255});
        pending_pixels.push_back({8'd0,   8'd255, 8'd0,   8'd255, 8'd0});
        pending_pixels.push_back({8'd0,   8'd255, 8'd0,   8'd255, 8'd255});
        pending_pixels.push_back({8'd137, 8'd42,  8'd200, 8'd17,  8'd0});
        pending_pixels.push_back({8'd137, 8'd42,  8'd200, 8'd17,  8'd255});
        // Weights next to the ends, around the middle, at the thirds and at a quarter.
        pending_pixels.push_back({8'd255, 8'd255, 8'd255, 8'd255, 8'd1});
        pending_pixels.push_back({8'd255, 8'd255, 8'd255, 8'd255, 8'd254});
        pending_pixels.push_back({8'd255, 8'd0,   8'd255, 8'd0,   8'd128});
        pending_pixels.push_back({8'd0,   8'd255, 8'd0,   8'd255, 8'd127});
        pending_pixels.push_back({8'd1,   8'd1,   8'd1,   8'd1,   8'd128});
        pending_pixels.push_back({8'd254, 8'd1,   8'd254, 8'd1,   8'd1});
        pending_pixels.push_back({8'd1,   8'd254, 8'd1,   8'd254, 8'd254});
        pending_pixels.push_back({8'd170, 8'd85,  8'd85,  8'd170, 8'd85});
        pending_pixels.push_back({8'd85,  8'd170, 8'd170, 8'd85,  8'd170});
        pending_pixels.push_back({8'd128, 8'd128, 8'd128, 8'd128, 8'd64});
        n_directed = pending_pixels.size();
        for (int k = 0; k < N_RANDOM; k++) begin
            px = random_pixel();
            pending_pixels.push_back(px);
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_pixels.size() != 0 || start) @(posedge i_clk);
        while (expected_blends.size() != 0) @(posedge i_clk);
        repeat (gsq_pkg::LATENCY + 4) @(posedge i_clk);

        $display("Blended %0d pixels (%0d directed, the rest random), %0d results checked.",
                 pixels_sent, n_directed, blends_checked);
        $display("%0d pixels had the weight at an end of its range; %0d errors seen.",
                 edge_weights, errors);
        if (errors == 0 && expected_blends.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
